// ===== design/wchd_pkg.sv =====
// Package: types and constants for the word count hash dictionary.
package wchd_pkg;

    localparam int HASH_SLOTS   = 4096;
    localparam int MAX_ENTRIES  = 1024;
    localparam int MAX_WORD_LEN = 99;

    localparam int SLOT_W  = $clog2(HASH_SLOTS);
    localparam int ENTRY_W = $clog2(MAX_ENTRIES);
    localparam int USED_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int BPOS_W  = $clog2(MAX_WORD_LEN);
    localparam int KEY_W   = $clog2(MAX_ENTRIES * MAX_WORD_LEN);
    localparam int PROBE_W = $clog2(HASH_SLOTS + 1);

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] word_byte;
        logic       word_end;
    } in_word_t;

    typedef struct packed {
        logic [9:0]  entry_index;
        logic [1:0]  status;
        logic [31:0] entry_count;
    } out_word_t;

endpackage

// ===== design/wchd_ram.sv =====
// Generic single-port write, single-port registered read RAM.
module wchd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/word_count_hash_dictionary.sv =====
// Word count hash dictionary with linear probing: the top level.
// Non-final bytes can follow back to back while no result waits in the
// output register. A final byte starts a sequencer that hashes the buffered
// word (one buffer read a cycle), then probes the slot table: it forms the
// slot address and reads the slot, checks the stored length of an occupied
// slot and, when the lengths agree, compares the word byte by byte; on a
// mismatch it moves on to the next slot. A count hit ends by updating the
// count, a lookup hit only reports it; a miss decides whether to insert, and
// an insert copies the word into the key store and then commits. The result
// waits in an output register, and the input stays held until it is taken.
// After reset a clearing pass over all HASH_SLOTS slots empties the slot
// table while in_ready stays low.
module word_count_hash_dictionary (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wchd_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wchd_pkg::out_word_t  out_data
);
    import wchd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_SLOT_RD, S_SLOT_WT, S_ENT_WT, S_CMP,
        S_CMP_WT, S_COUNT, S_COPY, S_INSERT, S_DONE
    } state_t;

    state_t state_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [BPOS_W-1:0]  pos_reg;
    logic [SLOT_W-1:0]  hash_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [PROBE_W-1:0] probes_reg;
    logic [USED_W-1:0]  used_reg;
    logic               lookup_reg;
    logic [ENTRY_W-1:0] ent_reg;
    logic               have_empty_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    // buffer RAM
    logic              buf_we;
    logic [BPOS_W-1:0] buf_waddr, buf_raddr;
    logic [7:0]        buf_wdata, buf_rdata;
    // slot RAM: valid + entry
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [ENTRY_W:0]  slot_wdata, slot_rdata;
    // key store
    logic              key_we;
    logic [KEY_W-1:0]  key_waddr, key_raddr;
    logic [7:0]        key_rdata;
    // lengths and counts
    logic               len_we;
    logic [LEN_W-1:0]   klen_rdata;
    logic               cnt_we;
    logic [ENTRY_W-1:0] cnt_waddr;
    logic [31:0]        cnt_wdata, cnt_rdata;
    logic [KEY_W-1:0]   ent_base;
    logic [ENTRY_W-1:0] rd_ent;

    wchd_ram #(.WIDTH(8), .DEPTH(MAX_WORD_LEN)) u_buf (
        .clk, .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
        .raddr(buf_raddr), .rdata(buf_rdata));
    wchd_ram #(.WIDTH(ENTRY_W + 1), .DEPTH(HASH_SLOTS)) u_slot (
        .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_reg), .rdata(slot_rdata));
    wchd_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES * MAX_WORD_LEN)) u_key (
        .clk, .we(key_we), .waddr(key_waddr), .wdata(buf_rdata),
        .raddr(key_raddr), .rdata(key_rdata));
    wchd_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_klen (
        .clk, .we(len_we), .waddr(used_reg[ENTRY_W-1:0]), .wdata(len_reg),
        .raddr(rd_ent), .rdata(klen_rdata));
    wchd_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_cnt (
        .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(rd_ent), .rdata(cnt_rdata));

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic accept;
    assign accept = in_valid && in_ready;

    // entry being read: the one named by the slot just read
    assign rd_ent   = slot_rdata[ENTRY_W-1:0];
    assign ent_base = KEY_W'(ent_reg) * KEY_W'(MAX_WORD_LEN);

    logic [BPOS_W-1:0] wr_pos;
    assign wr_pos = (len_reg == LEN_W'(MAX_WORD_LEN)) ? BPOS_W'(MAX_WORD_LEN - 1)
                                                      : len_reg[BPOS_W-1:0];
    logic [BPOS_W-1:0] pos_inc;
    assign pos_inc = pos_reg + 1'b1;
    logic last_pos;
    assign last_pos = (LEN_W'(pos_inc) == len_reg) || (len_reg == '0);

    always_comb
    begin
        buf_we    = accept;
        buf_waddr = wr_pos;
        buf_wdata = in_data.word_byte;
        buf_raddr = pos_reg;
        slot_we    = (state_reg == S_CLEAR) || (state_reg == S_INSERT);
        slot_waddr = slot_reg;
        slot_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, used_reg[ENTRY_W-1:0]};
        key_we    = (state_reg == S_COPY) && (pos_reg != '0);
        key_waddr = KEY_W'(used_reg[ENTRY_W-1:0]) * KEY_W'(MAX_WORD_LEN)
                    + KEY_W'(pos_reg) - 1'b1;
        key_raddr = ent_base + KEY_W'(pos_reg);
        len_we    = (state_reg == S_INSERT);
        cnt_we    = (state_reg == S_INSERT) || (state_reg == S_COUNT && !lookup_reg);
        cnt_waddr = (state_reg == S_INSERT) ? used_reg[ENTRY_W-1:0] : ent_reg;
        cnt_wdata = (state_reg == S_INSERT) ? 32'd1
                  : ((cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 32'd1);
    end

    // sign-extended byte added into the hash
    logic [SLOT_W-1:0] sbyte;
    assign sbyte = SLOT_W'({{(SLOT_W){buf_rdata[7]}}, buf_rdata});
    logic hash_go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            len_reg        <= '0;
            pos_reg        <= '0;
            hash_reg       <= '0;
            slot_reg       <= '0;
            probes_reg     <= '0;
            used_reg       <= '0;
            lookup_reg     <= 1'b0;
            ent_reg        <= '0;
            have_empty_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hash_go_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    slot_reg <= slot_reg + 1'b1;
                    if (slot_reg == SLOT_W'(HASH_SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (len_reg != LEN_W'(MAX_WORD_LEN))
                        begin
                            len_reg <= len_reg + 1'b1;
                        end
                        if (in_data.word_end)
                        begin
                            lookup_reg  <= (in_data.opcode == OP_LOOKUP);
                            pos_reg     <= '0;
                            hash_reg    <= '0;
                            hash_go_reg <= 1'b0;
                            state_reg   <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    // one buffer read a cycle; read data is registered behind its address, so
                    // the last byte is folded in while forming the slot
                    if (hash_go_reg)
                    begin
                        hash_reg <= (hash_reg << 8) + hash_reg + sbyte;
                    end
                    if (last_pos)
                    begin
                        state_reg  <= S_SLOT_RD;
                        probes_reg <= '0;
                    end
                    else
                    begin
                        hash_go_reg <= 1'b1;
                        pos_reg     <= pos_inc;
                    end
                end
                S_SLOT_RD:
                begin
                    slot_reg  <= (hash_reg << 8) + hash_reg + sbyte;
                    state_reg <= S_SLOT_WT;
                end
                S_SLOT_WT:
                begin
                    if (probes_reg == PROBE_W'(HASH_SLOTS))
                    begin
                        have_empty_reg <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_ENT_WT;
                    end
                end
                S_ENT_WT:
                begin
                    // slot data valid now; entry RAMs read rd_ent
                    if (!slot_rdata[ENTRY_W])
                    begin
                        have_empty_reg <= 1'b1;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        ent_reg   <= rd_ent;
                        pos_reg   <= '0;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (klen_rdata != len_reg)
                    begin
                        slot_reg   <= slot_reg + 1'b1;
                        probes_reg <= probes_reg + 1'b1;
                        state_reg  <= S_SLOT_WT;
                    end
                    else
                    begin
                        state_reg <= S_CMP_WT;
                    end
                end
                S_CMP_WT:
                begin
                    // compare byte at pos_reg (addresses set last cycle)
                    if (buf_rdata != key_rdata)
                    begin
                        slot_reg   <= slot_reg + 1'b1;
                        probes_reg <= probes_reg + 1'b1;
                        state_reg  <= S_SLOT_WT;
                        pos_reg    <= '0;
                    end
                    else if (last_pos)
                    begin
                        state_reg <= S_COUNT;
                    end
                    else
                    begin
                        pos_reg   <= pos_inc;
                        state_reg <= S_CMP;
                    end
                end
                S_COUNT:
                begin
                    out_reg.entry_index <= 10'(ent_reg);
                    out_reg.status      <= ST_FOUND;
                    out_reg.entry_count <= cnt_we ? cnt_wdata : cnt_rdata;
                    out_valid_reg       <= 1'b1;
                    len_reg             <= '0;
                    state_reg           <= S_IDLE;
                end
                S_DONE:
                begin
                    if (!lookup_reg && have_empty_reg &&
                        used_reg != USED_W'(MAX_ENTRIES))
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_COPY;
                    end
                    else
                    begin
                        out_reg.entry_index <= '0;
                        out_reg.status      <= lookup_reg ? ST_ABSENT : ST_FULL;
                        out_reg.entry_count <= '0;
                        out_valid_reg       <= 1'b1;
                        len_reg             <= '0;
                        state_reg           <= S_IDLE;
                    end
                end
                S_COPY:
                begin
                    // key write trails buffer read: registered read data lands at pos_reg - 1
                    if (LEN_W'(pos_reg) == len_reg)
                    begin
                        state_reg <= S_INSERT;
                    end
                    else
                    begin
                        pos_reg <= pos_inc;
                    end
                end
                S_INSERT:
                begin
                    out_reg.entry_index <= 10'(used_reg[ENTRY_W-1:0]);
                    out_reg.status      <= ST_INSERTED;
                    out_reg.entry_count <= 32'd1;
                    out_valid_reg       <= 1'b1;
                    used_reg            <= used_reg + 1'b1;
                    len_reg             <= '0;
                    state_reg           <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(MAX_ENTRIES))
        else $error("entry count overflow");
    a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT) |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("insert did not advance entries");
`endif
endmodule
